[rtl/fnps_pkg.sv]
// ----------------------------------------------------------------------------
// fnps_pkg
// Shared types and constants for the synthesizer divider calculation.
// ----------------------------------------------------------------------------
package fnps_pkg;

  localparam int TGT_W  = 30;
  localparam int REF_W  = 25;
  localparam int BAND_W = 3;
  localparam int INT_W  = 8;
  localparam int FRAC_W = 20;
  localparam int RATE_W = 24;
  localparam int X_W    = REF_W + 1;

  localparam logic [REF_W-1:0] REF_RESET = REF_W'(26000000);

  localparam logic [TGT_W-1:0] LIMIT_0 = TGT_W'(705000000);
  localparam logic [TGT_W-1:0] LIMIT_1 = TGT_W'(525000000);
  localparam logic [TGT_W-1:0] LIMIT_2 = TGT_W'(353000000);
  localparam logic [TGT_W-1:0] LIMIT_3 = TGT_W'(239000000);
  localparam logic [TGT_W-1:0] LIMIT_4 = TGT_W'(177000000);

  // floor(x / 3) == (x * RECIP3) >> RECIP3_SH for any x below 2^32.
  localparam logic [31:0] RECIP3    = 32'hAAAA_AAAB;
  localparam int          RECIP3_SH = 33;

  typedef enum logic [BAND_W-1:0] {
    BAND_DIV4  = 3'd0,
    BAND_DIV6  = 3'd1,
    BAND_DIV8  = 3'd2,
    BAND_DIV12 = 3'd3,
    BAND_DIV16 = 3'd4,
    BAND_DIV24 = 3'd5
  } band_t;

  function automatic band_t band_of(input logic [TGT_W-1:0] tgt);
    band_t b;
    b = BAND_DIV4;
    if (tgt < LIMIT_0) b = BAND_DIV6;
    if (tgt < LIMIT_1) b = BAND_DIV8;
    if (tgt < LIMIT_2) b = BAND_DIV12;
    if (tgt < LIMIT_3) b = BAND_DIV16;
    if (tgt < LIMIT_4) b = BAND_DIV24;
    return b;
  endfunction

  // The output divider is 2^a or 3 * 2^a; this gives the shift a of 2 * ref.
  function automatic logic [2:0] band_shift(input band_t b);
    logic [2:0] s;
    case (b)
      BAND_DIV4:  s = 3'd2;
      BAND_DIV6:  s = 3'd1;
      BAND_DIV8:  s = 3'd3;
      BAND_DIV12: s = 3'd2;
      BAND_DIV16: s = 3'd4;
      BAND_DIV24: s = 3'd3;
      default:    s = 3'd2;
    endcase
    return s;
  endfunction

  function automatic logic band_by3(input band_t b);
    return (b == BAND_DIV6) || (b == BAND_DIV12) || (b == BAND_DIV24);
  endfunction

endpackage

[rtl/fnps_req_if.sv]
// ----------------------------------------------------------------------------
// fnps_req_if
// Request channel carrying a target carrier frequency.
// ----------------------------------------------------------------------------
interface fnps_req_if;
  logic        valid;
  logic        ready;
  logic [29:0] target_freq;

  modport source (output valid, output target_freq, input ready);
  modport sink   (input valid, input target_freq, output ready);
endinterface

[rtl/fnps_rsp_if.sv]
// ----------------------------------------------------------------------------
// fnps_rsp_if
// Response channel carrying the synthesizer settings.
// ----------------------------------------------------------------------------
interface fnps_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  band_code;
  logic [7:0]  pll_integer;
  logic [19:0] pll_fraction;

  modport source (output valid, output band_code, output pll_integer,
                  output pll_fraction, input ready);
  modport sink   (input valid, input band_code, input pll_integer,
                  input pll_fraction, output ready);
endinterface

[rtl/fractional_n_pll_setting.sv]
// ----------------------------------------------------------------------------
// fractional_n_pll_setting
// Converts a target carrier frequency into band, integer and fraction words.
// ----------------------------------------------------------------------------
// A word on req carries target_freq in hertz; one word leaves on rsp with
// band_code, pll_integer and pll_fraction for that request, in order.
// The user writes the reference frequency through cfg_we and cfg_wdata only
// while the block holds no request in flight; the block does not check it.
// Three front stages pick the band, form twice the reference shifted by the
// divider's power of two, and finish the division by three with a
// reciprocal multiply. A restoring divider of 30 + FRACTION_BITS stages,
// one quotient bit per stage, then divides the target extended by
// FRACTION_BITS zero bits by the phase detector rate, which yields both
// the integer quotient and the fraction in one pass.
// A new word is accepted every cycle while no finished word waits on a
// stalled receiver.
// When the receiver stalls with a finished word waiting, the whole pipeline
// holds, empty slots included. Reset empties the pipeline and loads the
// reference register with 26 MHz.
// ----------------------------------------------------------------------------
module fractional_n_pll_setting #(
  parameter int FRACTION_BITS = 19
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [fnps_pkg::REF_W-1:0] cfg_wdata,
  fnps_req_if.sink                  req,
  fnps_rsp_if.source                rsp
);
  import fnps_pkg::*;

  localparam int DW = TGT_W + FRACTION_BITS;

  logic [REF_W-1:0] reference_freq;
  logic             advance;

  logic             a_vld;
  logic [TGT_W-1:0] a_tgt;
  band_t            a_band;
  logic [X_W-1:0]   a_x;
  logic             a_by3;

  logic             b_vld;
  logic [TGT_W-1:0] b_tgt;
  band_t            b_band;
  logic [X_W-1:0]   b_x;
  logic             b_by3;
  logic [X_W+31:0]  b_prod;

  logic              d_vld  [0:DW];
  logic [TGT_W-1:0]  d_tgt_unused;
  logic [RATE_W-1:0] d_rate [0:DW];
  logic [RATE_W-1:0] d_rem  [0:DW];
  logic [DW-1:0]     d_num  [0:DW];
  logic [DW-1:0]     d_q    [0:DW];
  band_t             d_band [0:DW];
  logic              d_zero [0:DW];

  logic [RATE_W-1:0]  c_rate;
  logic [FRACTION_BITS:0] frac_full;
  logic [FRAC_W+FRACTION_BITS:0] frac_ext;
  band_t in_band;
  logic [X_W-1:0] in_x2;

  assign advance   = !d_vld[DW] || rsp.ready;
  assign req.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_freq <= REF_RESET;
    end else if (cfg_we) begin
      reference_freq <= cfg_wdata;
    end
  end

  assign in_band = band_of(req.target_freq);
  assign in_x2   = {reference_freq, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
      b_vld <= 1'b0;
    end else if (advance) begin
      a_vld <= req.valid;
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      a_tgt  <= req.target_freq;
      a_band <= in_band;
      a_x    <= in_x2 >> band_shift(in_band);
      a_by3  <= band_by3(in_band);
      b_tgt  <= a_tgt;
      b_band <= a_band;
      b_x    <= a_x;
      b_by3  <= a_by3;
      b_prod <= a_x * RECIP3;
    end
  end

  assign c_rate = b_by3 ? RATE_W'(b_prod >> RECIP3_SH) : RATE_W'(b_x);
  assign d_tgt_unused = b_tgt;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld[0] <= 1'b0;
    end else if (advance) begin
      d_vld[0] <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      d_rate[0] <= c_rate;
      d_rem[0]  <= '0;
      d_num[0]  <= {d_tgt_unused, {FRACTION_BITS{1'b0}}};
      d_q[0]    <= '0;
      d_band[0] <= b_band;
      d_zero[0] <= (c_rate == '0);
    end
  end

  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [RATE_W:0] r2;
    logic [RATE_W:0] diff;
    logic            ge;

    assign r2   = {d_rem[k], d_num[k][DW-1]};
    assign diff = r2 - {1'b0, d_rate[k]};
    assign ge   = (r2 >= {1'b0, d_rate[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        d_vld[k+1] <= 1'b0;
      end else if (advance) begin
        d_vld[k+1] <= d_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        d_rate[k+1] <= d_rate[k];
        d_rem[k+1]  <= ge ? diff[RATE_W-1:0] : r2[RATE_W-1:0];
        d_num[k+1]  <= {d_num[k][DW-2:0], 1'b0};
        d_q[k+1]    <= {d_q[k][DW-2:0], ge};
        d_band[k+1] <= d_band[k];
        d_zero[k+1] <= d_zero[k];
      end
    end
  end

  assign frac_full = {1'b1, d_q[DW][FRACTION_BITS-1:0]};
  assign frac_ext  = {{FRAC_W{1'b0}}, frac_full};

  assign rsp.valid        = d_vld[DW];
  assign rsp.band_code    = d_band[DW];
  assign rsp.pll_integer  = d_zero[DW] ? {INT_W{1'b1}}
                          : d_q[DW][FRACTION_BITS +: INT_W] - INT_W'(1);
  assign rsp.pll_fraction = d_zero[DW] ? {FRAC_W{1'b1}} : frac_ext[FRAC_W-1:0];

  a_band_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.band_code <= 3'd5))
    else $error("band code out of range");

  a_zero_rate: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && d_zero[DW]) |-> (rsp.pll_integer == 8'hFF))
    else $error("zero rate word not saturated");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid)
    else $error("word out right after reset");

  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (d_vld[0] && !advance) |=> d_vld[0])
    else $error("pipeline lost a word during a stall");

endmodule
